/* rtl/fcg_pkg.sv */
// fcg_pkg: shared types and constants of the fillet corner geometry core.
// Holds the CORDIC gain and arctangent table, and the divider widths.
// No dependencies.
package fcg_pkg;

    // Q2.30 trig values with headroom for CORDIC growth
    localparam int TRIG_W = 33;
    // products of Q16.16 values with Q2.30 values
    localparam int NUM_W = 64;
    // quotient bits kept by the divider; larger quotients saturate
    localparam int QBITS = 35;
    localparam int QUO_W = QBITS + 1;
    // binary angle: 2^32 is a full turn
    localparam int BAM_W = 32;

    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [NUM_W-1:0]  num_t;
    typedef logic signed [QUO_W-1:0]  quo_t;
    typedef logic [BAM_W-1:0]         bam_t;

    // start value of x, compensates the CORDIC gain (Q2.30)
    localparam trig_t CORDIC_GAIN = 33'sd652032874;

    // atan(2^-i) as binary angle, 2^32 = 360 degrees
    localparam int ATAN_LEN = 30;
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1
    };

endpackage

/* rtl/fillet_corner_geometry_core.sv */
// fillet_corner_geometry_core: fillet center and tangent points at a corner.
// Accepts one transaction per cycle while the result side does not stall.
// The depth is set by the CORDIC stages and the one-bit-per-stage divider.
// A stall on the result side holds every stage; nothing is lost or repeated.
// Reset clears the valid bits only; the data path needs no reset.
module fillet_corner_geometry_core
    import fcg_pkg::*;
#(
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 18
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic [30:0]        seg_length,
    input  logic signed [25:0] entry_angle,
    input  logic signed [25:0] exit_angle,
    input  logic [30:0]        radius,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [31:0] center_x,
    output logic signed [31:0] center_y,
    output logic signed [31:0] exit_tangent_x,
    output logic signed [31:0] entry_tangent_x,
    output logic               alternate_case,
    output logic               degenerate
);

    // angle to binary angle: v = 45q + r, bam = q*2^(28-F) + round(r*2^(28-F)/45)
    localparam int V_W     = 27;
    localparam int RCP_SH  = 34;
    localparam int PROD_W  = 57;
    localparam int Q_W     = PROD_W - RCP_SH;
    localparam int SH_Q    = 28 - FRAC_BITS;
    localparam int SH_T    = 29 - FRAC_BITS;
    localparam logic signed [29:0] BAM_RECIP = 30'(((64'd1 << RCP_SH) / 45) + 1);
    localparam bam_t QUARTER = 32'h4000_0000;
    localparam bam_t HALF    = 32'h8000_0000;

    // pipeline positions
    localparam int P   = 6 + CORDIC_STAGES;
    localparam int DL  = QBITS + 4;
    localparam int LAT = P + DL + 4;

    localparam int X1_W  = 34;
    localparam int SUM_W = 37;
    localparam num_t RND = 64'sd536870912;

    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic [30:0]        l1;
        logic [30:0]        rad;
        logic               alt;
    } side_t;

    typedef struct packed {
        logic signed [X1_W-1:0] x1;
        logic signed [X1_W-1:0] y1;
        logic                   deg;
        logic                   alt;
    } tail_t;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] s_max;
        logic signed [SUM_W-1:0] s_min;
        s_max = SUM_W'(64'sd2147483647);
        s_min = SUM_W'(-64'sd2147483648);
        if (v > s_max)
            return 32'sh7FFF_FFFF;
        else if (v < s_min)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    logic adv;
    logic vld_reg [1:LAT];

    // stall control: the whole pipe moves together
    assign adv        = !vld_reg[LAT] || result_ready;
    assign item_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[1] <= item_valid;
            for (int k = 2; k <= LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // stage 1: capture, form the four base angles in half units
    logic signed [V_W-1:0]    v_in    [4];
    logic signed [V_W-1:0]    v1_reg  [4];
    logic signed [V_W-1:0]    v2_reg  [4];
    logic signed [PROD_W-1:0] prod_reg [4];
    logic signed [Q_W-1:0]    q3_reg  [4];
    logic [5:0]               r3_reg  [4];
    bam_t                     bam_raw [4];
    logic [31:0]              frac_tab [64];
    side_t                    side_reg [1:P+1];

    assign v_in[0] = {entry_angle, 1'b0};
    assign v_in[1] = V_W'(entry_angle) - V_W'(exit_angle);
    assign v_in[2] = V_W'(entry_angle) + V_W'(exit_angle);
    assign v_in[3] = {exit_angle, 1'b0};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 4; k++)
                v1_reg[k] <= v_in[k];
            side_reg[1] <= '{x0: start_x, y0: start_y, l1: seg_length, rad: radius,
                             alt: (exit_angle < entry_angle)};
            for (int k = 2; k <= P + 1; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // rounded fraction of a turn for remainders 0..44
    for (genvar i = 0; i < 64; i++)
    begin : g_frac
        assign frac_tab[i] = (i < 45) ? 32'(((i << SH_T) + 45) / 90) : 32'd0;
    end

    // stages 2 to 4: quotient by reciprocal, remainder fix, binary angle
    for (genvar k = 0; k < 4; k++)
    begin : g_bam
        logic signed [Q_W-1:0] qe;
        logic signed [29:0]    rr;
        logic                  ge45;
        logic [31:0]           qx;

        assign qe   = prod_reg[k][PROD_W-1:RCP_SH];
        assign rr   = v2_reg[k] - qe * 30'sd45;
        assign ge45 = rr >= 30'sd45;
        assign qx   = 32'(q3_reg[k]);
        assign bam_raw[k] = (qx << SH_Q) + frac_tab[r3_reg[k]];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                prod_reg[k] <= v1_reg[k] * BAM_RECIP;
                v2_reg[k]   <= v1_reg[k];
                q3_reg[k]   <= ge45 ? qe + Q_W'(1) : qe;
                r3_reg[k]   <= ge45 ? 6'(rr - 30'sd45) : 6'(rr);
            end
        end
    end

    bam_t bam_a1_reg;
    bam_t bam_hb_reg;
    bam_t bam_th_reg;
    bam_t bam_a2_reg;
    logic bflag_reg [4:P];
    bam_t bam_hb;

    assign bam_hb = bam_raw[1] + QUARTER;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bam_a1_reg   <= bam_raw[0];
            bam_hb_reg   <= bam_hb;
            bam_th_reg   <= bam_raw[2] + QUARTER;
            bam_a2_reg   <= bam_raw[3];
            bflag_reg[4] <= (bam_hb == '0) || (bam_hb == HALF);
            for (int k = 5; k <= P; k++)
                bflag_reg[k] <= bflag_reg[k-1];
        end
    end

    // four CORDIC pipes
    trig_t ca1, sa1, chb, shb, ct, st, c4r, s4r;

    fcg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_a1 (
        .clk(clk), .en(adv), .bam(bam_a1_reg), .cos_val(ca1), .sin_val(sa1));
    fcg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_hb (
        .clk(clk), .en(adv), .bam(bam_hb_reg), .cos_val(chb), .sin_val(shb));
    fcg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_th (
        .clk(clk), .en(adv), .bam(bam_th_reg), .cos_val(ct), .sin_val(st));
    fcg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_a2 (
        .clk(clk), .en(adv), .bam(bam_a2_reg), .cos_val(c4r), .sin_val(s4r));

    // M1: half-turn sign flips for the alternate case, products
    logic               alt_p;
    logic signed [31:0] l1_s;
    logic signed [31:0] rad_s;
    trig_t              ct_sel, st_sel, c4_sel, c3_sel;

    num_t  m1_px_reg, m1_py_reg, m1_pcx_reg, m1_pcy_reg, m1_prc_reg;
    trig_t m1_c3_reg, m1_c4_reg, m1_shb_reg;
    logic  m1_deg_reg, m1_alt_reg;

    assign alt_p  = side_reg[P].alt;
    assign l1_s   = {1'b0, side_reg[P].l1};
    assign rad_s  = {1'b0, side_reg[P].rad};
    assign ct_sel = alt_p ? -ct : ct;
    assign st_sel = alt_p ? -st : st;
    assign c4_sel = alt_p ? -c4r + (s4r & '0) : c4r;
    assign c3_sel = alt_p ? ca1 : -ca1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_px_reg  <= l1_s * ca1;
            m1_py_reg  <= l1_s * sa1;
            m1_pcx_reg <= rad_s * ct_sel;
            m1_pcy_reg <= rad_s * st_sel;
            m1_prc_reg <= rad_s * chb;
            m1_c3_reg  <= c3_sel;
            m1_c4_reg  <= c4_sel;
            m1_shb_reg <= shb;
            m1_deg_reg <= bflag_reg[P] || (shb == '0);
            m1_alt_reg <= alt_p;
        end
    end

    // M2: corner point and r*cos(b/2), rounded from Q2.30 products
    num_t                   px_rnd, py_rnd, prc_rnd;
    logic signed [X1_W-1:0] m2_x1_reg, m2_y1_reg;
    trig_t                  m2_rc_reg, m2_c3_reg, m2_c4_reg, m2_shb_reg;
    num_t                   m2_pcx_reg, m2_pcy_reg;
    logic                   m2_deg_reg, m2_alt_reg;

    assign px_rnd  = (m1_px_reg + RND) >>> 30;
    assign py_rnd  = (m1_py_reg + RND) >>> 30;
    assign prc_rnd = (m1_prc_reg + RND) >>> 30;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_x1_reg  <= X1_W'(side_reg[P+1].x0) + X1_W'(px_rnd);
            m2_y1_reg  <= X1_W'(side_reg[P+1].y0) + X1_W'(py_rnd);
            m2_rc_reg  <= TRIG_W'(prc_rnd);
            m2_c3_reg  <= m1_c3_reg;
            m2_c4_reg  <= m1_c4_reg;
            m2_shb_reg <= m1_shb_reg;
            m2_pcx_reg <= m1_pcx_reg;
            m2_pcy_reg <= m1_pcy_reg;
            m2_deg_reg <= m1_deg_reg;
            m2_alt_reg <= m1_alt_reg;
        end
    end

    // M3: tangent numerators
    num_t  m3_p4_reg, m3_p3_reg, m3_pcx_reg, m3_pcy_reg;
    trig_t m3_shb_reg;
    tail_t m3_tail_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m3_p4_reg   <= m2_rc_reg * m2_c4_reg;
            m3_p3_reg   <= m2_rc_reg * m2_c3_reg;
            m3_pcx_reg  <= m2_pcx_reg;
            m3_pcy_reg  <= m2_pcy_reg;
            m3_shb_reg  <= m2_shb_reg;
            m3_tail_reg <= '{x1: m2_x1_reg, y1: m2_y1_reg, deg: m2_deg_reg,
                             alt: m2_alt_reg};
        end
    end

    // four divisions by sin(b/2)
    quo_t qcx, qcy, q4, q3;

    fcg_divider u_div_cx (.clk(clk), .en(adv), .num(m3_pcx_reg), .den(m3_shb_reg), .quo(qcx));
    fcg_divider u_div_cy (.clk(clk), .en(adv), .num(m3_pcy_reg), .den(m3_shb_reg), .quo(qcy));
    fcg_divider u_div_x4 (.clk(clk), .en(adv), .num(m3_p4_reg),  .den(m3_shb_reg), .quo(q4));
    fcg_divider u_div_x3 (.clk(clk), .en(adv), .num(m3_p3_reg),  .den(m3_shb_reg), .quo(q3));

    tail_t tail_reg [1:DL];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tail_reg[1] <= m3_tail_reg;
            for (int k = 2; k <= DL; k++)
                tail_reg[k] <= tail_reg[k-1];
        end
    end

    // output register: add, saturate, override on a zero sine
    tail_t              tl;
    logic signed [31:0] cx_sat, cy_sat, x4_sat, x3_sat;
    logic signed [31:0] cx_reg, cy_reg, x4_reg, x3_reg;
    logic               alt_reg, deg_reg;

    assign tl     = tail_reg[DL];
    assign cx_sat = sat32(SUM_W'(tl.x1) + SUM_W'(qcx));
    assign cy_sat = sat32(SUM_W'(tl.y1) + SUM_W'(qcy));
    assign x4_sat = sat32(SUM_W'(tl.x1) + SUM_W'(q4));
    assign x3_sat = sat32(SUM_W'(tl.x1) + SUM_W'(q3));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg  <= tl.deg ? 32'sh7FFF_FFFF : cx_sat;
            cy_reg  <= tl.deg ? 32'sh7FFF_FFFF : cy_sat;
            x4_reg  <= tl.deg ? 32'sh7FFF_FFFF : x4_sat;
            x3_reg  <= tl.deg ? 32'sh7FFF_FFFF : x3_sat;
            alt_reg <= tl.alt;
            deg_reg <= tl.deg;
        end
    end

    assign result_valid    = vld_reg[LAT];
    assign center_x        = cx_reg;
    assign center_y        = cy_reg;
    assign exit_tangent_x  = x4_reg;
    assign entry_tangent_x = x3_reg;
    assign alternate_case  = alt_reg;
    assign degenerate      = deg_reg;

endmodule

/* rtl/fcg_cordic.sv */
// fcg_cordic: pipelined rotation-mode CORDIC, one stage per iteration.
// Takes a binary angle, gives cosine and sine in Q2.30.
// Depends on fcg_pkg.
module fcg_cordic
    import fcg_pkg::*;
#(
    parameter int STAGES = 18
)
(
    input  logic  clk,
    input  logic  en,
    input  bam_t  bam,
    output trig_t cos_val,
    output trig_t sin_val
);

    localparam logic [1:0] QUAD_II  = 2'b01;
    localparam logic [1:0] QUAD_III = 2'b10;

    trig_t x_reg [0:STAGES];
    trig_t y_reg [0:STAGES];
    trig_t z_reg [0:STAGES];
    logic  neg_reg [0:STAGES];
    trig_t cos_reg;
    trig_t sin_reg;
    logic  fold;
    bam_t  bam_f;

    // fold quadrants II and III onto IV and I, negate at the end
    assign fold  = (bam[31:30] == QUAD_II) || (bam[31:30] == QUAD_III);
    assign bam_f = fold ? {~bam[31], bam[30:0]} : bam;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= CORDIC_GAIN;
            y_reg[0]   <= '0;
            z_reg[0]   <= {bam_f[31], bam_f};
            neg_reg[0] <= fold;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        trig_t xs;
        trig_t ys;
        trig_t at;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        assign at = {1'b0, ATAN_TAB[i]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][TRIG_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + at;
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    // undo the quadrant fold
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= neg_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
            sin_reg <= neg_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

/* rtl/fcg_divider.sv */
// fcg_divider: pipelined signed divider, rounds to nearest, ties away from zero.
// One quotient bit per stage; quotients of 2^QBITS or more saturate.
// Depends on fcg_pkg.
module fcg_divider
    import fcg_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  num_t  num,
    input  trig_t den,
    output quo_t  quo
);

    localparam int UN_W = NUM_W - 1;
    localparam int HI_W = UN_W - QBITS;

    num_t              num_abs;
    trig_t             den_abs;
    logic [UN_W-1:0]   un0_reg;
    logic [31:0]       ud0_reg;
    logic              neg0_reg;
    logic [UN_W-1:0]   un1_reg;
    logic [31:0]       ud1_reg;
    logic              neg1_reg;
    logic [HI_W-1:0]   hi1;
    logic              ovf1;

    logic [31:0]       rem_reg [0:QBITS];
    logic [QBITS-1:0]  low_reg [0:QBITS];
    logic [QBITS-1:0]  q_reg   [0:QBITS];
    logic [31:0]       ud_reg  [0:QBITS];
    logic              neg_reg [0:QBITS];
    logic              ovf_reg [0:QBITS];
    logic [QBITS-1:0]  mag;
    quo_t              mag_s;
    quo_t              quo_reg;

    assign num_abs = num[NUM_W-1] ? -num : num;
    assign den_abs = den[TRIG_W-1] ? -den : den;

    // magnitudes and sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            un0_reg  <= num_abs[UN_W-1:0];
            ud0_reg  <= den_abs[31:0];
            neg0_reg <= num[NUM_W-1] ^ den[TRIG_W-1];
        end
    end

    // add half the divisor for rounding
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            un1_reg  <= un0_reg + UN_W'(ud0_reg[31:1]);
            ud1_reg  <= ud0_reg;
            neg1_reg <= neg0_reg;
        end
    end

    // overflow check on the high part, partial remainder start
    assign hi1  = un1_reg[UN_W-1:QBITS];
    assign ovf1 = 32'(hi1) >= ud1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= ovf1 ? 32'd0 : 32'(hi1);
            low_reg[0] <= un1_reg[QBITS-1:0];
            q_reg[0]   <= '0;
            ud_reg[0]  <= ud1_reg;
            neg_reg[0] <= neg1_reg;
            ovf_reg[0] <= ovf1;
        end
    end

    // restoring division, one bit per stage
    for (genvar k = 0; k < QBITS; k++)
    begin : g_bit
        logic [32:0] trial;
        logic        ge;

        assign trial = {rem_reg[k], low_reg[k][QBITS-1-k]};
        assign ge    = trial >= {1'b0, ud_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? 32'(trial - {1'b0, ud_reg[k]}) : trial[31:0];
                low_reg[k+1] <= low_reg[k];
                q_reg[k+1]   <= {q_reg[k][QBITS-2:0], ge};
                ud_reg[k+1]  <= ud_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    // saturate and apply sign
    assign mag   = ovf_reg[QBITS] ? {QBITS{1'b1}} : q_reg[QBITS];
    assign mag_s = {1'b0, mag};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= neg_reg[QBITS] ? -mag_s : mag_s;
        end
    end

    assign quo = quo_reg;

endmodule
